// File: hw/rtl/bpts_pkg.sv
// ----------------------------------------------------------------------------
// bpts_pkg
// Shared types and constants of the bitmap priority task scheduler.
// ----------------------------------------------------------------------------
package bpts_pkg;

    localparam int KIND_W    = 3;
    localparam int ID_W      = 6;
    localparam int PRIO_W    = 4;
    localparam int TICKS_W   = 16;
    localparam int QUANTUM_W = 8;

    localparam logic [QUANTUM_W-1:0] RESET_QUANTUM = 8'd5;

    typedef enum logic [KIND_W-1:0] {
        K_TICK   = 3'd0,
        K_CREATE = 3'd1,
        K_YIELD  = 3'd2,
        K_SLEEP  = 3'd3,
        K_BLOCK  = 3'd4,
        K_WAKE   = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        SRC_TID,
        SRC_SCAN,
        SRC_CUR
    } t_put_src;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SCAN_CHK,
        S_SCAN_NEXT,
        S_PUT_RD,
        S_PUT_WR,
        S_PRE_RD,
        S_PRE_CHK,
        S_TAKE_A,
        S_TAKE_B,
        S_SLICE_RD,
        S_SLICE_CHK,
        S_EXP_TAKE,
        S_PICK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic     ready;
        logic     accept;
        logic     clock_inc;
        logic     scan_clr;
        logic     scan_inc;
        logic     wake_done;
        logic     create_wr;
        logic     sleep_do;
        logic     valid_clr;
        logic     put_setup;
        t_put_src put_src;
        logic     put_inactive;
        logic     put_wr;
        logic     pre_rd;
        logic     take_a;
        logic     take_b;
        logic     slice_wr;
        logic     swap;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  create_ok;
        logic  wake_ok;
        logic  sleep_ok;
        logic  allow;
        logic  cur_valid;
        logic  scan_asleep;
        logic  scan_last;
        logic  wake_due;
        logic  pre_hit;
        logic  take_single;
        logic  slice_expire;
        logic  act_empty;
        logic  oth_empty;
        logic  out_free;
    } t_status;

endpackage

// File: hw/rtl/bpts_channels.sv
// ----------------------------------------------------------------------------
// bpts channels
// Event and result channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface bpts_req_if;
    import bpts_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    task_id;
    logic [PRIO_W-1:0]  task_priority;
    logic [TICKS_W-1:0] sleep_ticks;
    logic               allow_preempt;

    modport source (output valid, kind, task_id, task_priority, sleep_ticks, allow_preempt,
                    input ready);
    modport sink   (input valid, kind, task_id, task_priority, sleep_ticks, allow_preempt,
                    output ready);
endinterface

interface bpts_rsp_if;
    import bpts_pkg::*;

    logic            valid;
    logic            ready;
    logic [ID_W-1:0] running_id;
    logic            running_valid;
    logic            switched;
    logic            arrays_swapped;

    modport source (output valid, running_id, running_valid, switched, arrays_swapped,
                    input ready);
    modport sink   (input valid, running_id, running_valid, switched, arrays_swapped,
                    output ready);
endinterface

// File: hw/rtl/bpts_ram.sv
// ----------------------------------------------------------------------------
// bpts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/bpts_datapath.sv
// ----------------------------------------------------------------------------
// bpts_datapath
// Task tables, priority FIFOs, ready bitmaps, clock and result register.
// ----------------------------------------------------------------------------
module bpts_datapath #(
    parameter int NUM_PRIORITIES = 15,
    parameter int MAX_TASKS      = 64,
    parameter int CLOCK_BITS     = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpts_pkg::t_cmd                i_cmd,
    output bpts_pkg::t_status             o_status,
    input  logic [bpts_pkg::KIND_W-1:0]   i_kind,
    input  logic [bpts_pkg::ID_W-1:0]     i_task_id,
    input  logic [bpts_pkg::PRIO_W-1:0]   i_task_priority,
    input  logic [bpts_pkg::TICKS_W-1:0]  i_sleep_ticks,
    input  logic                          i_allow_preempt,
    input  logic                          i_cfg_we,
    input  logic [bpts_pkg::QUANTUM_W-1:0] i_cfg_wdata,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [bpts_pkg::ID_W-1:0]     o_running_id,
    output logic                          o_running_valid,
    output logic                          o_switched,
    output logic                          o_arrays_swapped
);
    import bpts_pkg::*;

    localparam int TW = $clog2(MAX_TASKS);
    localparam int PW = $clog2(NUM_PRIORITIES);
    localparam int FQ = 2 * NUM_PRIORITIES;
    localparam int QW = $clog2(FQ);

    // held event item
    logic [KIND_W-1:0]    r_kind;
    logic [ID_W-1:0]      r_tid;
    logic [PRIO_W-1:0]    r_prio;
    logic [TICKS_W-1:0]   r_ticks;
    logic                 r_allow;
    logic [TW-1:0]        r_old_id;
    logic                 r_old_valid;
    logic                 r_swap;

    // scheduler state
    logic [TW-1:0]             r_cur;
    logic                      r_cur_valid;
    logic                      r_sel;
    logic [NUM_PRIORITIES-1:0] r_bitmap [2];
    logic [CLOCK_BITS-1:0]     r_clock;
    logic [QUANTUM_W-1:0]      r_quantum;
    logic [TW-1:0]             r_head [FQ];
    logic [TW-1:0]             r_tail [FQ];
    logic [MAX_TASKS-1:0]      r_asleep;
    logic [MAX_TASKS-1:0]      r_queued;

    // operation operands
    logic [TW-1:0] r_scan;
    logic [TW-1:0] r_put_t;
    logic          r_put_arr;
    logic [PW-1:0] r_put_prio;
    logic [QW-1:0] r_take_q;

    // result register
    logic            r_out_valid;
    logic [ID_W-1:0] r_out_id;
    logic            r_out_run;
    logic            r_out_sw;
    logic            r_out_swp;

    // RAM read data
    logic [PW-1:0]         w_prio_rdata;
    logic [TW-1:0]         w_link_rdata;
    logic [QUANTUM_W-1:0]  w_slice_rdata;
    logic [CLOCK_BITS-1:0] w_wake_rdata;

    logic [TW-1:0]             w_tid_idx;
    logic                      w_tid_ok;
    logic                      w_tid_free;
    logic [PW-1:0]             w_prio_sat;
    logic [NUM_PRIORITIES-1:0] w_act_bm;
    logic [NUM_PRIORITIES-1:0] w_oth_bm;
    logic [PW-1:0]             w_take_p;
    logic [QW-1:0]             w_take_q;
    logic [TW-1:0]             w_take_t;
    logic [QW-1:0]             w_put_q;
    logic                      w_put_hit;
    logic                      w_expire;
    logic [QUANTUM_W-1:0]      w_slice_wdata;
    logic [TW-1:0]             w_put_src;

    assign w_tid_idx  = TW'(r_tid);
    assign w_tid_ok   = (32'(r_tid) < MAX_TASKS);
    assign w_tid_free = !(r_cur_valid && (r_cur == w_tid_idx))
                        && !r_queued[w_tid_idx] && !r_asleep[w_tid_idx];
    assign w_prio_sat = (32'(r_prio) >= NUM_PRIORITIES) ? PW'(NUM_PRIORITIES - 1)
                                                        : PW'(r_prio);

    assign w_act_bm = r_bitmap[r_sel];
    assign w_oth_bm = r_bitmap[~r_sel];

    // lowest set bit is the most urgent priority
    always_comb begin
        w_take_p = PW'(NUM_PRIORITIES - 1);
        for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
            if (w_act_bm[i]) begin
                w_take_p = PW'(i);
            end
        end
    end

    assign w_take_q = (r_sel ? QW'(NUM_PRIORITIES) : QW'(0)) + QW'(w_take_p);
    assign w_take_t = r_head[w_take_q];
    assign w_put_q  = (r_put_arr ? QW'(NUM_PRIORITIES) : QW'(0)) + QW'(w_prio_rdata);
    assign w_put_hit = r_bitmap[r_put_arr][w_prio_rdata];
    assign w_expire  = (w_slice_rdata <= QUANTUM_W'(1));

    always_comb begin
        if (i_cmd.create_wr || w_expire) begin
            w_slice_wdata = r_quantum;
        end else begin
            w_slice_wdata = w_slice_rdata - QUANTUM_W'(1);
        end
    end

    always_comb begin
        case (i_cmd.put_src)
            SRC_TID:  w_put_src = w_tid_idx;
            SRC_SCAN: w_put_src = r_scan;
            SRC_CUR:  w_put_src = r_cur;
            default:  w_put_src = r_cur;
        endcase
    end

    bpts_ram #(.WIDTH(PW), .DEPTH(MAX_TASKS)) u_prio_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.create_wr),
        .i_waddr (w_tid_idx),
        .i_wdata (w_prio_sat),
        .i_raddr (i_cmd.pre_rd ? r_cur : r_put_t),
        .o_rdata (w_prio_rdata)
    );

    bpts_ram #(.WIDTH(TW), .DEPTH(MAX_TASKS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.put_wr && w_put_hit),
        .i_waddr (r_tail[w_put_q]),
        .i_wdata (r_put_t),
        .i_raddr (w_take_t),
        .o_rdata (w_link_rdata)
    );

    bpts_ram #(.WIDTH(QUANTUM_W), .DEPTH(MAX_TASKS)) u_slice_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.create_wr || i_cmd.slice_wr),
        .i_waddr (i_cmd.create_wr ? w_tid_idx : r_cur),
        .i_wdata (w_slice_wdata),
        .i_raddr (r_cur),
        .o_rdata (w_slice_rdata)
    );

    bpts_ram #(.WIDTH(CLOCK_BITS), .DEPTH(MAX_TASKS)) u_wake_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.sleep_do),
        .i_waddr (r_cur),
        .i_wdata (r_clock + CLOCK_BITS'(r_ticks)),
        .i_raddr (r_scan),
        .o_rdata (w_wake_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_sel       <= 1'b0;
            r_bitmap[0] <= '0;
            r_bitmap[1] <= '0;
            r_clock     <= CLOCK_BITS'(1);
            r_quantum   <= RESET_QUANTUM;
            r_asleep    <= '0;
            r_queued    <= '0;
            r_swap      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_quantum <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_kind      <= i_kind;
                r_tid       <= i_task_id;
                r_prio      <= i_task_priority;
                r_ticks     <= i_sleep_ticks;
                r_allow     <= i_allow_preempt;
                r_old_id    <= r_cur;
                r_old_valid <= r_cur_valid;
                r_swap      <= 1'b0;
            end
            if (i_cmd.clock_inc) begin
                r_clock <= r_clock + CLOCK_BITS'(1);
            end
            if (i_cmd.scan_clr) begin
                r_scan <= '0;
            end
            if (i_cmd.scan_inc) begin
                r_scan <= r_scan + TW'(1);
            end
            if (i_cmd.wake_done) begin
                r_asleep[r_scan] <= 1'b0;
            end
            if (i_cmd.sleep_do) begin
                r_asleep[r_cur] <= 1'b1;
                r_cur_valid     <= 1'b0;
            end
            if (i_cmd.valid_clr) begin
                r_cur_valid <= 1'b0;
            end
            if (i_cmd.put_setup) begin
                r_put_t   <= w_put_src;
                r_put_arr <= r_sel ^ i_cmd.put_inactive;
            end
            // append to the tail of the FIFO for this priority
            if (i_cmd.put_wr) begin
                if (!w_put_hit) begin
                    r_head[w_put_q]                  <= r_put_t;
                    r_bitmap[r_put_arr][w_prio_rdata] <= 1'b1;
                end
                r_tail[w_put_q]   <= r_put_t;
                r_queued[r_put_t] <= 1'b1;
                r_put_prio        <= w_prio_rdata;
            end
            // pop the head of the most urgent FIFO into the running slot
            if (i_cmd.take_a) begin
                if (w_take_t == r_tail[w_take_q]) begin
                    r_bitmap[r_sel][w_take_p] <= 1'b0;
                end
                r_take_q           <= w_take_q;
                r_cur              <= w_take_t;
                r_cur_valid        <= 1'b1;
                r_queued[w_take_t] <= 1'b0;
            end
            if (i_cmd.take_b) begin
                r_head[r_take_q] <= w_link_rdata;
            end
            if (i_cmd.swap) begin
                r_sel  <= ~r_sel;
                r_swap <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_out_id    <= r_cur_valid ? ID_W'(r_cur) : '0;
                r_out_run   <= r_cur_valid;
                r_out_sw    <= (r_cur_valid != r_old_valid)
                               || (r_cur_valid && (r_cur != r_old_id));
                r_out_swp   <= r_swap;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.kind         = t_kind'(r_kind);
        o_status.create_ok    = w_tid_ok && w_tid_free;
        o_status.wake_ok      = w_tid_ok && w_tid_free;
        o_status.sleep_ok     = (r_ticks != '0);
        o_status.allow        = r_allow;
        o_status.cur_valid    = r_cur_valid;
        o_status.scan_asleep  = r_asleep[r_scan];
        o_status.scan_last    = (r_scan == TW'(MAX_TASKS - 1));
        o_status.wake_due     = (w_wake_rdata <= r_clock);
        o_status.pre_hit      = r_cur_valid && (r_put_prio < w_prio_rdata);
        o_status.take_single  = (w_take_t == r_tail[w_take_q]);
        o_status.slice_expire = w_expire;
        o_status.act_empty    = (w_act_bm == '0);
        o_status.oth_empty    = (w_oth_bm == '0);
        o_status.out_free     = !r_out_valid || i_out_ready;
    end

    assign o_out_valid      = r_out_valid;
    assign o_running_id     = r_out_id;
    assign o_running_valid  = r_out_run;
    assign o_switched       = r_out_sw;
    assign o_arrays_swapped = r_out_swp;
endmodule

// File: hw/rtl/bpts_ctrl.sv
// ----------------------------------------------------------------------------
// bpts_ctrl
// Event sequencer: steps the datapath through put, take, scan and pick.
// ----------------------------------------------------------------------------
module bpts_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  bpts_pkg::t_status  i_status,
    output bpts_pkg::t_cmd     o_cmd
);
    import bpts_pkg::*;

    t_state r_state, n_state;
    t_state r_put_ret, n_put_ret;
    t_state r_take_ret, n_take_ret;
    logic   r_in_tick, n_in_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_put_ret  <= S_IDLE;
            r_take_ret <= S_IDLE;
            r_in_tick  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_put_ret  <= n_put_ret;
            r_take_ret <= n_take_ret;
            r_in_tick  <= n_in_tick;
        end
    end

    // next state
    always_comb begin
        n_state    = r_state;
        n_put_ret  = r_put_ret;
        n_take_ret = r_take_ret;
        n_in_tick  = r_in_tick;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state   = S_DISPATCH;
                    n_in_tick = 1'b0;
                end
            end
            S_DISPATCH: begin
                n_state = S_PICK;
                case (i_status.kind)
                    K_TICK: begin
                        n_state   = S_SCAN;
                        n_in_tick = 1'b1;
                    end
                    K_CREATE: begin
                        if (i_status.create_ok) begin
                            n_state   = S_PUT_RD;
                            n_put_ret = S_PICK;
                        end
                    end
                    K_YIELD: begin
                        if (i_status.cur_valid) begin
                            n_state   = S_PUT_RD;
                            n_put_ret = S_PICK;
                        end
                    end
                    K_WAKE: begin
                        if (i_status.wake_ok) begin
                            n_state   = S_PUT_RD;
                            n_put_ret = S_PRE_RD;
                        end
                    end
                    default: n_state = S_PICK;
                endcase
            end
            S_SCAN: begin
                if (i_status.scan_asleep) begin
                    n_state = S_SCAN_CHK;
                end else if (i_status.scan_last) begin
                    n_state = S_SLICE_RD;
                end
            end
            S_SCAN_CHK: begin
                if (i_status.wake_due) begin
                    n_state   = S_PUT_RD;
                    n_put_ret = S_PRE_RD;
                end else begin
                    n_state = S_SCAN_NEXT;
                end
            end
            S_SCAN_NEXT: n_state = i_status.scan_last ? S_SLICE_RD : S_SCAN;
            S_PUT_RD:    n_state = S_PUT_WR;
            S_PUT_WR:    n_state = r_put_ret;
            S_PRE_RD:    n_state = S_PRE_CHK;
            S_PRE_CHK: begin
                if (i_status.pre_hit && (r_in_tick || i_status.allow)) begin
                    n_state    = S_PUT_RD;
                    n_put_ret  = S_TAKE_A;
                    n_take_ret = r_in_tick ? S_SCAN_NEXT : S_PICK;
                end else begin
                    n_state = r_in_tick ? S_SCAN_NEXT : S_PICK;
                end
            end
            S_TAKE_A:   n_state = i_status.take_single ? r_take_ret : S_TAKE_B;
            S_TAKE_B:   n_state = r_take_ret;
            S_SLICE_RD: n_state = i_status.cur_valid ? S_SLICE_CHK : S_PICK;
            S_SLICE_CHK: begin
                if (i_status.slice_expire) begin
                    n_state   = S_PUT_RD;
                    n_put_ret = S_EXP_TAKE;
                end else begin
                    n_state = S_PICK;
                end
            end
            S_EXP_TAKE: begin
                n_state    = S_TAKE_A;
                n_take_ret = S_PICK;
            end
            S_PICK: begin
                if (i_status.cur_valid) begin
                    n_state = S_OUT;
                end else if (!i_status.act_empty || !i_status.oth_empty) begin
                    n_state    = S_TAKE_A;
                    n_take_ret = S_OUT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        o_cmd.put_src = SRC_CUR;
        case (r_state)
            S_IDLE: begin
                o_cmd.ready  = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_DISPATCH: begin
                case (i_status.kind)
                    K_TICK: begin
                        o_cmd.clock_inc = 1'b1;
                        o_cmd.scan_clr  = 1'b1;
                    end
                    K_CREATE: begin
                        o_cmd.create_wr = i_status.create_ok;
                        o_cmd.put_setup = i_status.create_ok;
                        o_cmd.put_src   = SRC_TID;
                    end
                    // requeue the runner and drop it so the pick takes the next one
                    K_YIELD: begin
                        o_cmd.put_setup = i_status.cur_valid;
                        o_cmd.valid_clr = i_status.cur_valid;
                    end
                    K_SLEEP: o_cmd.sleep_do = i_status.cur_valid && i_status.sleep_ok;
                    K_BLOCK: o_cmd.valid_clr = i_status.cur_valid;
                    K_WAKE: begin
                        o_cmd.put_setup = i_status.wake_ok;
                        o_cmd.put_src   = SRC_TID;
                    end
                    default: o_cmd.put_setup = 1'b0;
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_inc = !i_status.scan_asleep && !i_status.scan_last;
            end
            S_SCAN_CHK: begin
                o_cmd.wake_done = i_status.wake_due;
                o_cmd.put_setup = i_status.wake_due;
                o_cmd.put_src   = SRC_SCAN;
            end
            S_SCAN_NEXT: o_cmd.scan_inc = !i_status.scan_last;
            S_PUT_WR:    o_cmd.put_wr = 1'b1;
            S_PRE_RD:    o_cmd.pre_rd = 1'b1;
            S_PRE_CHK: begin
                o_cmd.put_setup = i_status.pre_hit && (r_in_tick || i_status.allow);
            end
            S_TAKE_A: o_cmd.take_a = 1'b1;
            S_TAKE_B: o_cmd.take_b = 1'b1;
            S_SLICE_CHK: begin
                o_cmd.slice_wr     = 1'b1;
                o_cmd.put_setup    = i_status.slice_expire;
                o_cmd.put_inactive = 1'b1;
            end
            S_EXP_TAKE: o_cmd.swap = i_status.act_empty;
            S_PICK: begin
                o_cmd.swap = !i_status.cur_valid && i_status.act_empty
                             && !i_status.oth_empty;
            end
            S_OUT: o_cmd.out_load = i_status.out_free;
            default: o_cmd.ready = 1'b0;
        endcase
    end

`ifndef SYNTHESIS
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_DISPATCH))
        else $error("accepted item not dispatched");

    a_take_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAKE_A) |-> !i_status.act_empty)
        else $error("take from empty active array");

    a_swap_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.swap |-> !i_status.oth_empty)
        else $error("swap toward empty array");

    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == S_IDLE))
        else $error("result loaded without return to idle");
`endif
endmodule

// File: hw/rtl/bitmap_priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// bitmap_priority_task_scheduler
// Two-array priority task scheduler with per-priority FIFOs and bitmaps.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one scheduler event per item (tick, create, yield, sleep,
//   block, wake); o_rsp returns exactly one result item per event giving the
//   running task, whether it changed and whether the arrays swapped.
//   i_cfg_we / i_cfg_wdata load the time quantum; write only while idle.
// Timing:
//   One event at a time; the next is accepted the cycle after the result is
//   loaded. A tick advances the clock and walks all MAX_TASKS sleep slots, one
//   per cycle past slots that are not asleep; each sleeper that is due is
//   woken and may preempt. The running slice is then checked, and on expiry
//   the runner moves to the other array before the pick.
// Reset:
//   Synchronous, active low. Clears bitmaps, sleep and queue flags, running
//   task, array select; clock restarts at one, quantum at five.
// Stall:
//   The result register holds an item while o_rsp.ready is low; the block may
//   already accept the next event, and holds its own result until free.
// ----------------------------------------------------------------------------
module bitmap_priority_task_scheduler #(
    parameter int NUM_PRIORITIES = 15,
    parameter int MAX_TASKS      = 64,
    parameter int CLOCK_BITS     = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bpts_req_if.sink                        i_req,
    bpts_rsp_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [bpts_pkg::QUANTUM_W-1:0]  i_cfg_wdata
);
    import bpts_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer: one state per datapath micro-operation
    bpts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // hold ready high only in idle
    assign i_req.ready = w_cmd.ready;

    bpts_datapath #(
        .NUM_PRIORITIES (NUM_PRIORITIES),
        .MAX_TASKS      (MAX_TASKS),
        .CLOCK_BITS     (CLOCK_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_kind           (i_req.kind),
        .i_task_id        (i_req.task_id),
        .i_task_priority  (i_req.task_priority),
        .i_sleep_ticks    (i_req.sleep_ticks),
        .i_allow_preempt  (i_req.allow_preempt),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_running_id     (o_rsp.running_id),
        .o_running_valid  (o_rsp.running_valid),
        .o_switched       (o_rsp.switched),
        .o_arrays_swapped (o_rsp.arrays_swapped)
    );
endmodule

// File: tb/sv/bitmap_priority_task_scheduler_test.sv
// ----------------------------------------------------------------------------
// bitmap_priority_task_scheduler_test
// Drives scheduler events through the request channel, predicts the running
// task after each event and checks every result item field by field.
// ----------------------------------------------------------------------------
module bitmap_priority_task_scheduler_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bpts_pkg::*;

    localparam int NPRIO  = 15;
    localparam int NTASKS = 64;

    typedef struct packed {
        t_kind              kind;
        logic [ID_W-1:0]    task_id;
        logic [PRIO_W-1:0]  prio;
        logic [TICKS_W-1:0] ticks;
        logic               allow;
    } t_event;

    typedef struct packed {
        logic [ID_W-1:0] running_id;
        logic            running_valid;
        logic            switched;
        logic            arrays_swapped;
    } t_sched_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [QUANTUM_W-1:0] i_cfg_wdata = '0;

    bpts_req_if req_ch ();
    bpts_rsp_if rsp_ch ();

    bitmap_priority_task_scheduler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Scheduler shadow state
    // ------------------------------------------------------------------
    logic [3:0]  sh_prio   [NTASKS];
    logic [5:0]  sh_next   [NTASKS];
    logic [7:0]  sh_slice  [NTASKS];
    logic [31:0] sh_wake   [NTASKS];
    logic        sh_asleep [NTASKS];
    logic        sh_queued [NTASKS];
    logic [5:0]  sh_head   [2*NPRIO];
    logic [5:0]  sh_tail   [2*NPRIO];
    logic [14:0] sh_bitmap [2];
    logic        sh_act;
    logic [5:0]  sh_cur;
    logic        sh_cur_ok;
    logic [31:0] sh_clock;
    logic [7:0]  sh_quantum;
    logic        sh_swapped;

    // slots that some queued create has named; wake only targets these
    bit          made_slot [NTASKS];

    t_event     pending_events[$];
    t_sched_out expected_runs[$];
    int  errors = 0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  n_switches = 0;
    int  n_swaps = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    int  rx_hold = 0;

    function automatic void enqueue_task(input int arr, input int t);
        int p;
        int q;
        p = int'(sh_prio[t]);
        q = arr * NPRIO + p;
        if (!sh_bitmap[arr][p]) begin
            sh_head[q] = 6'(t);
            sh_bitmap[arr][p] = 1'b1;
        end else begin
            sh_next[sh_tail[q]] = 6'(t);
        end
        sh_tail[q] = 6'(t);
        sh_queued[t] = 1'b1;
    endfunction

    function automatic int dequeue_task(input int arr);
        int p;
        int q;
        int t;
        p = 0;
        while (p + 1 < NPRIO && !sh_bitmap[arr][p]) p++;
        q = arr * NPRIO + p;
        t = int'(sh_head[q]);
        if (t == int'(sh_tail[q])) sh_bitmap[arr][p] = 1'b0;
        else sh_head[q] = sh_next[t];
        sh_queued[t] = 1'b0;
        return t;
    endfunction

    function automatic void pick_runner();
        if (sh_bitmap[sh_act] == '0) begin
            if (sh_bitmap[!sh_act] == '0) begin
                sh_cur_ok = 1'b0;
                return;
            end
            sh_act = !sh_act;
            sh_swapped = 1'b1;
        end
        sh_cur = 6'(dequeue_task(int'(sh_act)));
        sh_cur_ok = 1'b1;
    endfunction

    function automatic void make_ready(input int t, input bit allow);
        enqueue_task(int'(sh_act), t);
        if (allow && sh_cur_ok && sh_prio[t] < sh_prio[sh_cur]) begin
            enqueue_task(int'(sh_act), int'(sh_cur));
            sh_cur = 6'(dequeue_task(int'(sh_act)));
        end
    endfunction

    function automatic bit slot_idle(input int t);
        return !(sh_cur_ok && int'(sh_cur) == t) && !sh_queued[t] && !sh_asleep[t];
    endfunction

    task automatic reset_schedule();
        for (int i = 0; i < NTASKS; i++) begin
            sh_prio[i] = '0; sh_next[i] = '0; sh_slice[i] = '0; sh_wake[i] = '0;
            sh_asleep[i] = 1'b0; sh_queued[i] = 1'b0; made_slot[i] = 1'b0;
        end
        for (int i = 0; i < 2*NPRIO; i++) begin
            sh_head[i] = '0; sh_tail[i] = '0;
        end
        sh_bitmap[0] = '0; sh_bitmap[1] = '0;
        sh_act = 1'b0; sh_cur = '0; sh_cur_ok = 1'b0;
        sh_clock = 32'd1; sh_quantum = RESET_QUANTUM;
    endtask

    // Apply one event to the shadow state and return the running task after it.
    function automatic t_sched_out schedule_event(input t_event ev);
        t_sched_out r;
        logic [5:0] old_id;
        logic old_ok;
        int c;
        int p;
        old_id = sh_cur;
        old_ok = sh_cur_ok;
        sh_swapped = 1'b0;
        case (ev.kind)
            K_TICK: begin
                sh_clock = sh_clock + 32'd1;
                for (int t = 0; t < NTASKS; t++) begin
                    if (sh_asleep[t] && sh_wake[t] <= sh_clock) begin
                        sh_asleep[t] = 1'b0;
                        sh_wake[t] = '0;
                        make_ready(t, 1'b1);
                    end
                end
                if (sh_cur_ok) begin
                    c = int'(sh_cur);
                    if (sh_slice[c] <= 8'd1) begin
                        sh_slice[c] = sh_quantum;
                        enqueue_task(int'(!sh_act), c);
                        if (sh_bitmap[sh_act] == '0) begin
                            sh_act = !sh_act;
                            sh_swapped = 1'b1;
                        end
                        sh_cur = 6'(dequeue_task(int'(sh_act)));
                    end else begin
                        sh_slice[c]--;
                    end
                end
            end
            K_CREATE: begin
                if (slot_idle(int'(ev.task_id))) begin
                    p = (int'(ev.prio) >= NPRIO) ? NPRIO - 1 : int'(ev.prio);
                    sh_prio[ev.task_id] = 4'(p);
                    sh_slice[ev.task_id] = sh_quantum;
                    sh_wake[ev.task_id] = '0;
                    enqueue_task(int'(sh_act), int'(ev.task_id));
                end
            end
            K_YIELD: begin
                if (sh_cur_ok) begin
                    enqueue_task(int'(sh_act), int'(sh_cur));
                    pick_runner();
                end
            end
            K_SLEEP: begin
                if (sh_cur_ok && ev.ticks != '0) begin
                    sh_wake[sh_cur] = sh_clock + 32'(ev.ticks);
                    sh_asleep[sh_cur] = 1'b1;
                    sh_cur_ok = 1'b0;
                    pick_runner();
                end
            end
            K_BLOCK: begin
                if (sh_cur_ok) begin
                    sh_cur_ok = 1'b0;
                    pick_runner();
                end
            end
            K_WAKE: begin
                if (slot_idle(int'(ev.task_id))) make_ready(int'(ev.task_id), ev.allow);
            end
            default: ;
        endcase
        if (!sh_cur_ok) pick_runner();
        r.running_id = sh_cur_ok ? sh_cur : '0;
        r.running_valid = sh_cur_ok;
        r.switched = (sh_cur_ok != old_ok) || (sh_cur_ok && sh_cur != old_id);
        r.arrays_swapped = sh_swapped;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer the oldest pending item, idle in random bursts
    // ------------------------------------------------------------------
    int tx_gap = 0;
    initial begin
        req_ch.valid = 1'b0;
        req_ch.kind = '0;
        req_ch.task_id = '0;
        req_ch.task_priority = '0;
        req_ch.sleep_ticks = '0;
        req_ch.allow_preempt = 1'b0;
        rsp_ch.ready = 1'b0;
    end

    // Acceptance is sampled at the rising edge; the falling edge then advances.
    bit req_taken = 1'b0;
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && req_ch.valid && req_ch.ready;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            expected_runs.push_back(schedule_event(pending_events.pop_front()));
            n_sent++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (req_ch.valid && !req_taken) begin
            // hold the item until it is accepted
        end else if (tx_gap > 0) begin
            tx_gap--;
            req_ch.valid <= 1'b0;
        end else if (tx_idle_on && $urandom_range(0, 9) == 0) begin
            tx_gap = $urandom_range(1, 18);
            req_ch.valid <= 1'b0;
        end else if (pending_events.size() > 0) begin
            req_ch.valid <= 1'b1;
            req_ch.kind <= pending_events[0].kind;
            req_ch.task_id <= pending_events[0].task_id;
            req_ch.task_priority <= pending_events[0].prio;
            req_ch.sleep_ticks <= pending_events[0].ticks;
            req_ch.allow_preempt <= pending_events[0].allow;
        end else begin
            req_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result item against the oldest expectation
    // ------------------------------------------------------------------
    int rx_gap = 0;
    always @(posedge i_clk) begin
        t_sched_out want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_runs.size() == 0) begin
                $display("%0t: unexpected result id=%0d valid=%0b sw=%0b swap=%0b", $time,
                         rsp_ch.running_id, rsp_ch.running_valid, rsp_ch.switched,
                         rsp_ch.arrays_swapped);
                errors++;
            end else begin
                want = expected_runs.pop_front();
                n_checked++;
                n_switches += int'(want.switched);
                n_swaps += int'(want.arrays_swapped);
                if (rsp_ch.running_id !== want.running_id
                    || rsp_ch.running_valid !== want.running_valid
                    || rsp_ch.switched !== want.switched
                    || rsp_ch.arrays_swapped !== want.arrays_swapped) begin
                    $display("%0t: mismatch expected id=%0d valid=%0b sw=%0b swap=%0b",
                             $time, want.running_id, want.running_valid, want.switched,
                             want.arrays_swapped);
                    $display("%0t:          actual   id=%0d valid=%0b sw=%0b swap=%0b",
                             $time, rsp_ch.running_id, rsp_ch.running_valid,
                             rsp_ch.switched, rsp_ch.arrays_swapped);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (rx_hold > 0) begin
            // long hold-off: let the block back up into its input
            rx_hold--;
            rsp_ch.ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            rsp_ch.ready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
            rx_gap = $urandom_range(1, 18);
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic t_event make_event(input t_kind k, input int id, input int pr,
                                          input int tk, input bit al);
        t_event ev;
        ev.kind = k;
        ev.task_id = ID_W'(id);
        ev.prio = PRIO_W'(pr);
        ev.ticks = TICKS_W'(tk);
        ev.allow = al;
        return ev;
    endfunction

    // Pick a kind and a slot at random.
    function automatic t_event random_event(input int max_prio);
        t_event ev;
        int r;
        int id;
        r = $urandom_range(0, 99);
        id = $urandom_range(0, NTASKS - 1);
        ev = make_event(K_TICK, id, $urandom_range(0, max_prio), 0, $urandom_range(0, 1));
        if (r < 35) ev.kind = K_TICK;
        else if (r < 55) ev.kind = K_CREATE;
        else if (r < 65) ev.kind = K_YIELD;
        else if (r < 77) begin
            ev.kind = K_SLEEP;
            ev.ticks = ($urandom_range(0, 19) == 0) ? TICKS_W'($urandom)
                                                   : TICKS_W'($urandom_range(0, 12));
        end else if (r < 87) ev.kind = K_BLOCK;
        else ev.kind = K_WAKE;
        return ev;
    endfunction

    // Wait until every expected result has arrived and the block has settled.
    task automatic drain();
        while (pending_events.size() > 0 || expected_runs.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_quantum(input logic [QUANTUM_W-1:0] q);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= q;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sh_quantum = q;
    endtask

    // Queue a random event; only wake slots that have been created.
    task automatic push_random(input int max_prio);
        t_event ev;
        ev = random_event(max_prio);
        if (ev.kind == K_WAKE && !made_slot[ev.task_id]) ev.kind = K_CREATE;
        if (ev.kind == K_CREATE) made_slot[ev.task_id] = 1'b1;
        pending_events.push_back(ev);
    endtask

    initial begin
        logic [QUANTUM_W-1:0] quanta[5];
        quanta = '{8'd1, 8'd255, 8'd2, 8'd3, 8'd0};
        reset_schedule();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every kind, idle pick, preemption, zero sleep,
        // nothing runnable, swap on expiry, kinds without a runner.
        pending_events.push_back(make_event(K_YIELD, 0, 0, 0, 0));
        pending_events.push_back(make_event(K_BLOCK, 0, 0, 0, 0));
        pending_events.push_back(make_event(K_SLEEP, 0, 0, 5, 0));
        pending_events.push_back(make_event(K_TICK, 0, 0, 0, 0));
        pending_events.push_back(make_event(K_CREATE, 63, 14, 16'hFFFF, 1));
        pending_events.push_back(make_event(K_CREATE, 0, 15, 0, 0));
        pending_events.push_back(make_event(K_CREATE, 63, 3, 0, 0));
        pending_events.push_back(make_event(K_CREATE, 21, 0, 0, 0));
        pending_events.push_back(make_event(K_SLEEP, 0, 0, 0, 0));
        pending_events.push_back(make_event(K_SLEEP, 0, 0, 2, 0));
        pending_events.push_back(make_event(K_WAKE, 63, 0, 0, 1));
        pending_events.push_back(make_event(K_TICK, 0, 0, 0, 0));
        pending_events.push_back(make_event(K_TICK, 0, 0, 0, 0));
        pending_events.push_back(make_event(K_YIELD, 0, 0, 0, 0));
        repeat (6) pending_events.push_back(make_event(K_TICK, 0, 0, 0, 0));
        pending_events.push_back(make_event(K_BLOCK, 0, 0, 0, 0));
        pending_events.push_back(make_event(K_WAKE, 21, 0, 0, 0));
        pending_events.push_back(make_event(K_BLOCK, 0, 0, 0, 0));
        pending_events.push_back(make_event(K_WAKE, 0, 10, 0, 0));
        pending_events.push_back(make_event(K_BLOCK, 0, 0, 0, 0));
        foreach (pending_events[i]) begin
            if (pending_events[i].kind == K_CREATE) made_slot[pending_events[i].task_id] = 1'b1;
        end
        drain();

        // Random phases, each under its own quantum.
        foreach (quanta[i]) begin
            write_quantum(quanta[i]);
            for (int n = 0; n < 60; n++) push_random(i == 2 ? 15 : 14);
            if (i == 1) begin
                // fill the block while results are held off
                rx_hold = 400;
            end
            drain();
        end

        // Last stretch: full throughput, no idling on either side.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_quantum(8'd4);
        for (int n = 0; n < 80; n++) push_random(14);
        drain();

        $display("checked %0d results over %0d events: %0d switches, %0d array swaps",
                 n_checked, n_sent, n_switches, n_swaps);
        $display("quanta 0..255 exercised, with a long receiver hold-off");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end
endmodule
